@@ hdl/cidr_whitelist_match_table_assert.svh @@
// Assertion macros for the prefix match table.
`ifndef CIDR_WHITELIST_MATCH_TABLE_ASSERT_SVH
`define CIDR_WHITELIST_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CWMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CWMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cwmt_pkg.sv @@
// Shared types, constants and helpers of the prefix match table.
`default_nettype none

package cwmt_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // Item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_LEN = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // latch the incoming transaction
    logic issue;   // read the next table entry
    logic commit;  // update the table and load the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_scan;   // incoming transaction needs no table walk
    logic last_issue;  // current read is the last valid entry
    logic out_free;    // output register can take a result
  } sts_t;

  // Top n bits set, zero for n = 0
  function automatic logic [ADDR_W-1:0] length_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = ({1'b0, len} + 7'(i)) >= 7'(ADDR_W);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cwmt_in_if.sv @@
// Input channel: add or check transactions.
`default_nettype none

interface cwmt_in_if;
  import cwmt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  prefix_length;

  modport source (output valid, output kind, output address, output prefix_length,
                  input ready);
  modport sink   (input valid, input kind, input address, input prefix_length,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/cwmt_out_if.sv @@
// Result channel: status, match flag and entry count.
`default_nettype none

interface cwmt_out_if;
  import cwmt_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               matched;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output matched, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input matched, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/cwmt_ctrl.sv @@
// Controller state machine of the prefix match table.
`default_nettype none

module cwmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_rdy,
  input  cwmt_pkg::sts_t     sts,
  output cwmt_pkg::cmd_t     cmd
);
  import cwmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_rdy     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.skip_scan ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cwmt_dpath.sv @@
// Datapath: entry memory, scan counter, compare stage and result register.
`default_nettype none

module cwmt_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_kind,
  input  wire logic [cwmt_pkg::ADDR_W-1:0] in_address,
  input  wire logic [cwmt_pkg::LEN_W-1:0]  in_prefix_length,
  input  cwmt_pkg::cmd_t                 cmd,
  output cwmt_pkg::sts_t                 sts,
  input  wire logic                      out_rdy,
  output logic                           out_vld,
  output logic [cwmt_pkg::STAT_W-1:0]    out_status,
  output logic                           out_matched,
  output logic [cwmt_pkg::COUNT_W-1:0]   out_entry_count
);
  import cwmt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = ADDR_W + LEN_W;

  // Entry memory: {prefix, length}; valid entries are exactly slots below the count
  logic [DW-1:0] mem [TABLE_DEPTH];

  // Held transaction
  logic              kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] pfx_r;
  logic [LEN_W-1:0]  len_r;
  logic              bad_len_r;

  // Scan and compare
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rd_idx_r;
  logic [DW-1:0]     rd_data_r;
  logic              cmp_vld_r;
  logic [AW-1:0]     cmp_idx_r;
  logic              found_r;
  logic [AW-1:0]     found_idx_r;

  // Result register
  logic               out_vld_r;
  logic [STAT_W-1:0]  status_r;
  logic               matched_r;
  logic [COUNT_W-1:0] count_r;

  logic [ADDR_W-1:0] rd_pfx;
  logic [LEN_W-1:0]  rd_len;
  logic              hit;
  logic              bad_len_in;
  logic              has_free;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [STAT_W-1:0] status_nxt;

  assign rd_pfx = rd_data_r[DW-1:LEN_W];
  assign rd_len = rd_data_r[LEN_W-1:0];

  // Compare the entry read last cycle
  always_comb begin
    if (kind_r == KIND_CHECK) begin
      hit = cmp_vld_r && ((addr_r & length_mask(rd_len)) == rd_pfx);
    end else begin
      hit = cmp_vld_r && (rd_pfx == pfx_r);
    end
  end

  assign bad_len_in = (in_kind == KIND_ADD) && (in_prefix_length > MAX_LEN);
  assign has_free   = cnt_r < CW'(TABLE_DEPTH);

  // Status to the controller
  always_comb begin
    sts.skip_scan  = bad_len_in || (cnt_r == '0);
    sts.last_issue = rd_idx_r == CW'(cnt_r - CW'(1));
    sts.out_free   = !out_vld_r || out_rdy;
  end

  // Decide table update and status at commit
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = found_idx_r;
    cnt_nxt    = cnt_r;
    status_nxt = STATUS_OK;
    if (bad_len_r) begin
      status_nxt = STATUS_BAD_LEN;
    end else if (kind_r == KIND_ADD) begin
      if (found_r) begin
        wr_en = cmd.commit;
      end else if (has_free) begin
        wr_en   = cmd.commit;
        wr_addr = cnt_r[AW-1:0];
        cnt_nxt = CW'(cnt_r + CW'(1));
      end else begin
        status_nxt = STATUS_FULL;
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {pfx_r, len_r};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // Latch the transaction and track the compare slot
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      addr_r    <= in_address;
      pfx_r     <= in_address & length_mask(in_prefix_length);
      len_r     <= in_prefix_length;
      bad_len_r <= bad_len_in;
    end
    if (cmd.issue) begin
      cmp_idx_r <= rd_idx_r[AW-1:0];
    end
    if (hit && !found_r) begin
      found_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      status_r  <= status_nxt;
      matched_r <= (kind_r == KIND_CHECK) && found_r;
      count_r   <= COUNT_W'(cnt_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.accept) begin
        rd_idx_r <= '0;
        found_r  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          rd_idx_r <= CW'(rd_idx_r + CW'(1));
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_vld         = out_vld_r;
  assign out_status      = status_r;
  assign out_matched     = matched_r;
  assign out_entry_count = count_r;

endmodule

`default_nettype wire

@@ hdl/cidr_whitelist_match_table.sv @@
// Top level of the IPv4 prefix match table.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    kind, address, prefix_length
//   out_chan  out  valid/ready    status, matched, entry_count
//
// An add or check transaction walks the stored entries one per cycle through the
// single read port of the entry memory; the next transaction is taken only after
// its result is committed. The walk is skipped when the table is empty or the
// length is invalid.
// Reset is synchronous and clears the entry count; entry memory is not cleared.
// A result waits in the output register while the next transaction is taken;
// the block stalls in its final step only while that register is still full.
`default_nettype none

module cidr_whitelist_match_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cwmt_in_if.sink    in_chan,
  cwmt_out_if.source out_chan
);
  import cwmt_pkg::*;

  `include "cidr_whitelist_match_table_assert.svh"

  cmd_t cmd;
  sts_t sts;
  logic in_rdy;

  assign in_chan.ready = in_rdy;

  cwmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_rdy   (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  cwmt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_chan.kind),
    .in_address       (in_chan.address),
    .in_prefix_length (in_chan.prefix_length),
    .cmd              (cmd),
    .sts              (sts),
    .out_rdy          (out_chan.ready),
    .out_vld          (out_chan.valid),
    .out_status       (out_chan.status),
    .out_matched      (out_chan.matched),
    .out_entry_count  (out_chan.entry_count)
  );

  // One transaction in flight at a time
  `CWMT_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_rdy, "accepted while busy")
  // Table reads only while a transaction is in flight
  `CWMT_ASSERT_NOW(a_issue_busy, cmd.issue, !in_rdy, "table read while idle")
  // Commit presents a result and frees the input
  `CWMT_ASSERT_NEXT(a_commit_result, cmd.commit, out_chan.valid && in_rdy, "result not presented")

endmodule

`default_nettype wire
